// File: hw/rtl/apd_pkg.sv
// ----------------------------------------------------------------------------
// Addressed packet deframer package
// Shared types, codes and reset values of the deframer and its interfaces.
// ----------------------------------------------------------------------------
package apd_pkg;

    // Largest payload the buffer holds by default.
    localparam int PAYLOAD_MAX_DEF = 64;

    // Frame markers.
    localparam logic [7:0] MARK_HEAD = 8'h55;
    localparam logic [7:0] MARK_TAIL = 8'hAA;

    // Bit position of the continuation flag in a length byte.
    localparam int MORE_BIT = 7;

    // Register reset values.
    localparam logic [7:0] OWN_ID_RESET        = 8'd2;
    localparam logic [7:0] TYPE_COUNT_RESET    = 8'd16;
    localparam logic [7:0] TIMEOUT_TICKS_RESET = 8'd10;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        CFG_OWN_ID        = 2'd0,
        CFG_TYPE_COUNT    = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2
    } cfg_index_t;

    // Input word commands.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Parser stages.
    typedef enum logic [2:0] {
        ST_HEAD    = 3'd0,
        ST_TARGET  = 3'd1,
        ST_TYPE    = 3'd2,
        ST_SENDER  = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_PAYLOAD = 3'd5,
        ST_CHECK   = 3'd6,
        ST_TAIL    = 3'd7
    } stage_t;

    // Readout sequencer states.
    typedef enum logic [1:0] {
        RD_IDLE,
        RD_ISSUE,
        RD_LOAD
    } rd_state_t;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] msg_type;
        logic [7:0] sender;
        logic [6:0] payload_length;
        logic       has_payload;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic       last;
    } out_word_t;

endpackage

// File: hw/rtl/apd_in_if.sv
// ----------------------------------------------------------------------------
// Deframer input channel
// Valid/ready channel that carries received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
interface apd_in_if;

    logic             valid;
    logic             ready;
    apd_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: hw/rtl/apd_out_if.sv
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel that carries one payload byte of an accepted packet.
// ----------------------------------------------------------------------------
interface apd_out_if;

    logic              valid;
    logic              ready;
    apd_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: hw/rtl/addressed_packet_deframer.sv
// ----------------------------------------------------------------------------
// Addressed packet deframer
// Parses 0x55-framed addressed packets with an additive checksum from a byte
// stream and plays the payload of each good packet out one byte per word.
// ----------------------------------------------------------------------------
// Every input word, a received byte or a millisecond tick, is taken as soon
// as it is offered while the block is parsing. When a packet closes with a
// good footer the block stops taking input and reads its payload buffer out:
// the buffer is a synchronous memory with one read port, so each payload byte
// is first addressed and then loaded into the output register, and the input
// is held off until the last byte of the packet is loaded, also while the
// result side stalls. An empty packet skips the buffer read and gives a
// single word. Results wait in an output register, so the next input word is
// taken while the last result of a packet is still waiting to be picked up.
// Ticks arriving during readout simply wait on the input channel.
// ----------------------------------------------------------------------------
module addressed_packet_deframer #(
    parameter int PAYLOAD_MAX = apd_pkg::PAYLOAD_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    apd_in_if.sink      stream,
    apd_out_if.source   packet
);

    // Buffer address width; a one-entry buffer still gets one address bit.
    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    // Configuration registers.
    logic [7:0] own_id_reg;
    logic [7:0] type_count_reg;
    logic [7:0] timeout_ticks_reg;

    // Parser state.
    apd_pkg::stage_t stage_reg, stage_next;
    logic [7:0]  timeout_left_reg, timeout_left_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [1:0]  length_group_reg, length_group_next;
    logic [13:0] frame_length_reg, frame_length_next;
    logic [6:0]  fill_index_reg, fill_index_next;
    logic [7:0]  frame_type_reg, frame_type_next;
    logic [7:0]  frame_sender_reg, frame_sender_next;

    // Readout sequencer state.
    apd_pkg::rd_state_t rd_state_reg, rd_state_next;
    logic [5:0]  rd_idx_reg, rd_idx_next;
    logic        rd_empty_reg, rd_empty_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    apd_pkg::out_word_t out_word_reg, out_word_next;

    // Payload buffer and its ports.
    logic [7:0]    store_mem [PAYLOAD_MAX];
    logic [7:0]    mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;

    logic          in_accept;
    logic [7:0]    ch;
    logic [13:0]   len_merged;
    logic [1:0]    group_inc;
    logic [6:0]    fill_inc;
    logic          rd_last;

    assign stream.ready = (rd_state_reg == apd_pkg::RD_IDLE);
    assign in_accept    = stream.valid && stream.ready;
    assign ch           = stream.data.rx_byte;

    assign packet.valid = out_valid_reg;
    assign packet.data  = out_word_reg;

    // A length byte contributes its low seven bits, placed by its group.
    assign len_merged = frame_length_reg |
                        ((length_group_reg != 2'd0) ? {ch[6:0], 7'd0} : {7'd0, ch[6:0]});
    assign group_inc  = length_group_reg + 2'd1;
    assign fill_inc   = fill_index_reg + 7'd1;

    assign rd_last = rd_empty_reg || (({1'b0, rd_idx_reg} + 7'd1) == frame_length_reg[6:0]);

    // Configuration writes; an index outside the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg        <= apd_pkg::OWN_ID_RESET;
            type_count_reg    <= apd_pkg::TYPE_COUNT_RESET;
            timeout_ticks_reg <= apd_pkg::TIMEOUT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == apd_pkg::CFG_OWN_ID)
                own_id_reg <= cfg_data;
            else if (cfg_index == apd_pkg::CFG_TYPE_COUNT)
                type_count_reg <= cfg_data;
            else if (cfg_index == apd_pkg::CFG_TIMEOUT_TICKS)
                timeout_ticks_reg <= cfg_data;
        end
    end

    // Parser, readout sequencer and output register: next values.
    always_comb
    begin
        stage_next        = stage_reg;
        timeout_left_next = timeout_left_reg;
        running_sum_next  = running_sum_reg;
        length_group_next = length_group_reg;
        frame_length_next = frame_length_reg;
        fill_index_next   = fill_index_reg;
        frame_type_next   = frame_type_reg;
        frame_sender_next = frame_sender_reg;
        rd_state_next     = rd_state_reg;
        rd_idx_next       = rd_idx_reg;
        rd_empty_next     = rd_empty_reg;
        out_valid_next    = out_valid_reg && !packet.ready;
        out_word_next     = out_word_reg;
        mem_we            = 1'b0;
        mem_waddr         = fill_index_reg[AW-1:0];
        mem_re            = 1'b0;

        if (in_accept)
        begin
            if (stream.data.command == apd_pkg::CMD_TICK)
            begin
                if (timeout_left_reg != 8'd0)
                    timeout_left_next = timeout_left_reg - 8'd1;
            end
            else
            begin
                // An expired timer sends the parser to header search before the
                // byte is looked at; bytes reload it, rejects and tails clear it.
                timeout_left_next = timeout_ticks_reg;
                unique case ((timeout_left_reg == 8'd0) ? apd_pkg::ST_HEAD : stage_reg)
                    apd_pkg::ST_HEAD:
                    begin
                        stage_next = apd_pkg::ST_HEAD;
                        if (ch == apd_pkg::MARK_HEAD)
                        begin
                            stage_next       = apd_pkg::ST_TARGET;
                            running_sum_next = 8'd0;
                        end
                    end
                    apd_pkg::ST_TARGET:
                    begin
                        if (ch == own_id_reg)
                        begin
                            running_sum_next = running_sum_reg + ch;
                            stage_next       = apd_pkg::ST_TYPE;
                        end
                        else
                        begin
                            stage_next        = apd_pkg::ST_HEAD;
                            timeout_left_next = 8'd0;
                        end
                    end
                    apd_pkg::ST_TYPE:
                    begin
                        if (ch >= type_count_reg)
                        begin
                            stage_next        = apd_pkg::ST_HEAD;
                            timeout_left_next = 8'd0;
                        end
                        else
                        begin
                            frame_type_next  = ch;
                            running_sum_next = running_sum_reg + ch;
                            stage_next       = apd_pkg::ST_SENDER;
                        end
                    end
                    apd_pkg::ST_SENDER:
                    begin
                        frame_sender_next = ch;
                        running_sum_next  = running_sum_reg + ch;
                        frame_length_next = 14'd0;
                        length_group_next = 2'd0;
                        stage_next        = apd_pkg::ST_LENGTH;
                    end
                    apd_pkg::ST_LENGTH:
                    begin
                        frame_length_next = len_merged;
                        length_group_next = group_inc;
                        running_sum_next  = running_sum_reg + ch;
                        if (len_merged > 14'(PAYLOAD_MAX))
                        begin
                            stage_next        = apd_pkg::ST_HEAD;
                            timeout_left_next = 8'd0;
                        end
                        else if (!ch[apd_pkg::MORE_BIT])
                        begin
                            fill_index_next = 7'd0;
                            stage_next      = (len_merged == 14'd0) ? apd_pkg::ST_CHECK
                                                                    : apd_pkg::ST_PAYLOAD;
                        end
                        else if (group_inc >= 2'd2)
                        begin
                            // A third length group is never allowed.
                            stage_next        = apd_pkg::ST_HEAD;
                            timeout_left_next = 8'd0;
                        end
                    end
                    apd_pkg::ST_PAYLOAD:
                    begin
                        mem_we           = ({1'b0, fill_index_reg} < 8'(PAYLOAD_MAX));
                        fill_index_next  = fill_inc;
                        running_sum_next = running_sum_reg + ch;
                        if ({7'd0, fill_inc} >= frame_length_reg)
                            stage_next = apd_pkg::ST_CHECK;
                    end
                    apd_pkg::ST_CHECK:
                    begin
                        if (ch == running_sum_reg)
                            stage_next = apd_pkg::ST_TAIL;
                        else
                        begin
                            stage_next        = apd_pkg::ST_HEAD;
                            timeout_left_next = 8'd0;
                        end
                    end
                    apd_pkg::ST_TAIL:
                    begin
                        stage_next        = apd_pkg::ST_HEAD;
                        timeout_left_next = 8'd0;
                        if (ch == apd_pkg::MARK_TAIL)
                        begin
                            // Good footer: start the readout. An empty packet
                            // skips the buffer read.
                            rd_idx_next   = 6'd0;
                            rd_empty_next = (frame_length_reg == 14'd0);
                            rd_state_next = (frame_length_reg == 14'd0) ? apd_pkg::RD_LOAD
                                                                        : apd_pkg::RD_ISSUE;
                        end
                    end
                    default:
                    begin
                        stage_next = apd_pkg::ST_HEAD;
                    end
                endcase
            end
        end

        unique case (rd_state_reg)
            apd_pkg::RD_IDLE:
            begin
            end
            apd_pkg::RD_ISSUE:
            begin
                mem_re        = 1'b1;
                rd_state_next = apd_pkg::RD_LOAD;
            end
            apd_pkg::RD_LOAD:
            begin
                // The read data stays in mem_q until the output register is free.
                if (!out_valid_reg || packet.ready)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next.msg_type       = frame_type_reg;
                    out_word_next.sender         = frame_sender_reg;
                    out_word_next.payload_length = frame_length_reg[6:0];
                    out_word_next.has_payload    = !rd_empty_reg;
                    out_word_next.byte_index     = rd_idx_reg;
                    out_word_next.payload_byte   = rd_empty_reg ? 8'd0 : mem_q;
                    out_word_next.last           = rd_last;
                    if (rd_last)
                        rd_state_next = apd_pkg::RD_IDLE;
                    else
                    begin
                        rd_idx_next   = rd_idx_reg + 6'd1;
                        rd_state_next = apd_pkg::RD_ISSUE;
                    end
                end
            end
            default:
            begin
                rd_state_next = apd_pkg::RD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg        <= apd_pkg::ST_HEAD;
            timeout_left_reg <= 8'd0;
            running_sum_reg  <= 8'd0;
            length_group_reg <= 2'd0;
            frame_length_reg <= 14'd0;
            fill_index_reg   <= 7'd0;
            frame_type_reg   <= 8'd0;
            frame_sender_reg <= 8'd0;
            rd_state_reg     <= apd_pkg::RD_IDLE;
            rd_idx_reg       <= 6'd0;
            rd_empty_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            stage_reg        <= stage_next;
            timeout_left_reg <= timeout_left_next;
            running_sum_reg  <= running_sum_next;
            length_group_reg <= length_group_next;
            frame_length_reg <= frame_length_next;
            fill_index_reg   <= fill_index_next;
            frame_type_reg   <= frame_type_next;
            frame_sender_reg <= frame_sender_next;
            rd_state_reg     <= rd_state_next;
            rd_idx_reg       <= rd_idx_next;
            rd_empty_reg     <= rd_empty_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // The result word itself needs no reset; valid guards it.
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    // Payload buffer: one write port from the parser, one registered read
    // port for the readout. Writes and reads never share a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= ch;
        if (mem_re)
            mem_q <= store_mem[rd_idx_reg[AW-1:0]];
    end

endmodule

// File: hw/rtl/apd_checker.sv
// ----------------------------------------------------------------------------
// Addressed packet deframer checker
// Port-level assertions on the result stream of the deframer.
// ----------------------------------------------------------------------------
module apd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               stream_ready,
    input logic               packet_valid,
    input logic               packet_ready,
    input apd_pkg::out_word_t packet_data
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        packet_valid && !packet_ready |=> packet_valid && $stable(packet_data))
        else $error("result word changed while stalled");

    // An empty result is the only word of its packet.
    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        packet_valid && !packet_data.has_payload |->
            packet_data.last && packet_data.payload_length == 7'd0 &&
            packet_data.byte_index == 6'd0 && packet_data.payload_byte == 8'd0)
        else $error("malformed empty result");

    // A payload word lies inside its packet and last marks its final byte.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        packet_valid && packet_data.has_payload |->
            ({1'b0, packet_data.byte_index} < packet_data.payload_length) &&
            (packet_data.last ==
                (({1'b0, packet_data.byte_index} + 7'd1) == packet_data.payload_length)))
        else $error("byte index or last flag out of place");

    // While a packet is still being played out, input is held off.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        packet_valid && !packet_data.last |-> !stream_ready)
        else $error("input taken during readout");

endmodule

bind addressed_packet_deframer apd_checker u_apd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .stream_ready (stream.ready),
    .packet_valid (packet.valid),
    .packet_ready (packet.ready),
    .packet_data  (packet.data)
);
